/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands for the sorted key table; they compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SKT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skt assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define SKT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skt assertion failed");

`else

`define SKT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SKT_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/skt_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted key table package
// Sizes, request and result codes, and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_WIDTH   = 32;

    localparam int KEY_IN_W = 32;
    localparam int STAMP_W  = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;
    localparam int ECNT_W   = 7;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Request word: key in the low half, time stamp above it.
    localparam int I_NOW_LSB = KEY_IN_W;
    localparam int IN_DATA_W = ((KEY_IN_W + STAMP_W + 7) / 8) * 8;

    // Result word: hit, position, last-used stamp, entry count.
    localparam int O_POS_LSB   = 1;
    localparam int O_STAMP_LSB = O_POS_LSB + POS_W;
    localparam int O_CNT_LSB   = O_STAMP_LSB + STAMP_W;
    localparam int OUT_DATA_W  = ((O_CNT_LSB + ECNT_W + 7) / 8) * 8;

    localparam logic [ECNT_W-1:0] MAX_COUNT = ECNT_W'(TABLE_DEPTH);

    typedef enum logic [MODE_W-1:0] {
        MODE_CHECK  = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_PURGE  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_REFRESHED = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_PURGED    = 3'd5,
        ST_FOUND     = 3'd6
    } status_t;

    typedef struct packed {
        logic [STAMP_W-1:0]   stamp;
        logic [KEY_WIDTH-1:0] key;
    } entry_t;

    typedef struct packed {
        logic    load;      // latch the request and open the search window
        logic    purge;     // empty the table
        logic    srch_cmp;  // narrow the search window on the read entry
        logic    chk_cmp;   // test the entry at the final slot for a match
        logic    refresh;   // rewrite the stamp of the matching entry
        logic    shd_init;  // start closing the gap at the deleted slot
        logic    shd_rd;    // read the entry above the gap
        logic    shd_wr;    // move it down into the gap
        logic    dec;       // one entry fewer
        logic    shu_init;  // start opening a gap at the end of the table
        logic    shu_rd;    // read the entry below the gap
        logic    shu_wr;    // move it up into the gap
        logic    put;       // write the new entry into the gap, one more entry
        logic    emit;      // load the result register
        status_t res_status;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  search_more;
        logic  found;
        logic  full;
        logic  shd_more;
        logic  shu_more;
        logic  out_free;
    } sts_t;

endpackage

/* rtl/sorted_key_table_core.sv */
// ----------------------------------------------------------------------------
// Sorted key table core
// A table of up to 64 distinct keys kept in ascending order, each with a
// last-used stamp, serving check, add or refresh, delete and purge requests.
// ----------------------------------------------------------------------------
// Usage. Each request on the s_ channel carries a mode in s_tuser and a key
// and a time stamp in s_tdata. Every request gives exactly one result on the
// m_ channel: a status code in m_tuser, and hit, position, last-used stamp
// and entry count in m_tdata.
// Operation. A request is looked up by binary search over the entry memory,
// each halving step a read of the middle entry and a compare that narrows
// the window, then a check of the entry at the final slot for a match.
// An insert or a delete then moves the entries above the slot one place,
// each entry read and then written back one place along.
// A purge empties the table without a search.
// One request is worked on at a time. A result waits in the output register
// while the next request is accepted and searched; when the receiver stalls,
// the block holds that next result until the register drains and accepts
// nothing further meanwhile.
// Reset empties the table at once (the entry count goes to zero; the memory
// itself is not cleared) and drops any result not yet taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sorted_key_table_core (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Request channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata fields from bit 0: key (32 bits), now (32 bits).
    input  logic [skt_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser fields from bit 0: mode (2 bits).
    input  logic [skt_pkg::MODE_W-1:0]        s_tuser,

    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata fields from bit 0: hit (1), position (6), last_used (32),
    // entry_count (7), then two zero bits.
    output logic [skt_pkg::OUT_DATA_W-1:0]    m_tdata,
    // m_tuser fields from bit 0: status (3 bits).
    output logic [skt_pkg::STATUS_W-1:0]      m_tuser
);

    skt_pkg::cmd_t cmd;
    skt_pkg::sts_t sts;

    // The controller only sequences; every stored value of the table and of
    // the request lives in the datapath.
    skt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    skt_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Result fields, unpacked for the checks below.
    logic                          res_hit;
    logic [skt_pkg::STAMP_W-1:0]   res_stamp;
    logic [skt_pkg::ECNT_W-1:0]    res_count;
    skt_pkg::status_t              res_status;
    logic                          res_acted;
    logic                          res_check_hit;

    assign res_hit    = m_tdata[0];
    assign res_stamp  = m_tdata[skt_pkg::O_STAMP_LSB +: skt_pkg::STAMP_W];
    assign res_count  = m_tdata[skt_pkg::O_CNT_LSB +: skt_pkg::ECNT_W];
    assign res_status = skt_pkg::status_t'(m_tuser);

    // Statuses that act on a key already in the table.
    assign res_acted     = (res_status == skt_pkg::ST_FOUND)
                        || (res_status == skt_pkg::ST_REFRESHED)
                        || (res_status == skt_pkg::ST_DELETED);
    assign res_check_hit = (res_status == skt_pkg::ST_FOUND);

    // A request is never followed directly by another: once one is taken,
    // the block leaves the idle state to search it.
    `SKT_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // The table can never report more entries than it holds.
    `SKT_ASSERT_IMP(a_count_range, aclk, aresetn, m_tvalid, res_count <= skt_pkg::MAX_COUNT)

    // A hit only comes with a status that acted on an existing key.
    `SKT_ASSERT_IMP(a_hit_status, aclk, aresetn, m_tvalid && res_hit, res_acted)

    // The stored stamp is reported on a check hit only.
    `SKT_ASSERT_IMP(a_stamp_gated, aclk, aresetn, m_tvalid && !res_check_hit, res_stamp == '0)

endmodule

/* rtl/skt_dpath.sv */
// ----------------------------------------------------------------------------
// Sorted key table datapath
// Entry memory, search window, shift pointer, entry count and the result
// register, all driven by commands from the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skt_dpath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  skt_pkg::cmd_t                     cmd,
    output skt_pkg::sts_t                     sts,
    input  logic [skt_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [skt_pkg::MODE_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [skt_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [skt_pkg::STATUS_W-1:0]      m_tuser
);

    skt_pkg::entry_t mem [skt_pkg::TABLE_DEPTH];
    skt_pkg::entry_t rdata_reg;

    skt_pkg::mode_t                  mode_reg;
    logic [skt_pkg::KEY_WIDTH-1:0]   key_reg;
    logic [skt_pkg::STAMP_W-1:0]     now_reg;
    logic [skt_pkg::CNT_W-1:0]       lo_reg;
    logic [skt_pkg::CNT_W-1:0]       hi_reg;
    logic [skt_pkg::CNT_W-1:0]       ptr_reg;
    logic [skt_pkg::CNT_W-1:0]       count_reg;
    logic                            found_reg;
    logic [skt_pkg::STAMP_W-1:0]     stamp_reg;

    logic                            m_tvalid_reg;
    skt_pkg::status_t                out_status_reg;
    logic                            out_hit_reg;
    logic [skt_pkg::POS_W-1:0]       out_pos_reg;
    logic [skt_pkg::STAMP_W-1:0]     out_stamp_reg;
    logic [skt_pkg::ECNT_W-1:0]      out_cnt_reg;

    logic [skt_pkg::CNT_W:0]         lo_hi_sum;
    logic [skt_pkg::CNT_W-1:0]       mid;
    logic [skt_pkg::CNT_W-1:0]       ptr_inc;
    logic [skt_pkg::CNT_W-1:0]       ptr_dec;
    logic [skt_pkg::IDX_W-1:0]       rd_addr;
    logic [skt_pkg::IDX_W-1:0]       wr_addr;
    skt_pkg::entry_t                 wr_data;
    logic                            wr_en;
    logic                            pos_valid;

    assign lo_hi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = lo_hi_sum[skt_pkg::CNT_W:1];
    assign ptr_inc   = ptr_reg + 1'b1;
    assign ptr_dec   = ptr_reg - 1'b1;

    // The search reads the middle of the window every cycle; the shift loops
    // take the read port over while they run.
    always_comb begin
        if (cmd.shd_rd) begin
            rd_addr = ptr_inc[skt_pkg::IDX_W-1:0];
        end else if (cmd.shu_rd) begin
            rd_addr = ptr_dec[skt_pkg::IDX_W-1:0];
        end else begin
            rd_addr = mid[skt_pkg::IDX_W-1:0];
        end
    end

    always_comb begin
        wr_en = cmd.refresh | cmd.put | cmd.shd_wr | cmd.shu_wr;
        if (cmd.shd_wr || cmd.shu_wr) begin
            wr_addr = ptr_reg[skt_pkg::IDX_W-1:0];
            wr_data = rdata_reg;
        end else begin
            wr_addr = lo_reg[skt_pkg::IDX_W-1:0];
            wr_data = '{stamp: now_reg, key: key_reg};
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= skt_pkg::mode_t'(s_tuser);
            key_reg   <= skt_pkg::KEY_WIDTH'(s_tdata[skt_pkg::KEY_IN_W-1:0]);
            now_reg   <= s_tdata[skt_pkg::I_NOW_LSB +: skt_pkg::STAMP_W];
            lo_reg    <= '0;
            hi_reg    <= count_reg;
            found_reg <= 1'b0;
        end
        if (cmd.srch_cmp) begin
            if (rdata_reg.key < key_reg) begin
                lo_reg <= mid + 1'b1;
            end else begin
                hi_reg <= mid;
            end
        end
        if (cmd.chk_cmp) begin
            found_reg <= (lo_reg < count_reg) && (rdata_reg.key == key_reg);
            stamp_reg <= rdata_reg.stamp;
        end
        if (cmd.shd_init) begin
            ptr_reg <= lo_reg;
        end else if (cmd.shu_init) begin
            ptr_reg <= count_reg;
        end else if (cmd.shd_wr) begin
            ptr_reg <= ptr_inc;
        end else if (cmd.shu_wr) begin
            ptr_reg <= ptr_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.purge) begin
            count_reg <= '0;
        end else if (cmd.put) begin
            count_reg <= count_reg + 1'b1;
        end else if (cmd.dec) begin
            count_reg <= count_reg - 1'b1;
        end
    end

    // Position is reported only where a key was found, inserted or removed.
    assign pos_valid = (cmd.res_status == skt_pkg::ST_ADDED)
                    || (cmd.res_status == skt_pkg::ST_REFRESHED)
                    || (cmd.res_status == skt_pkg::ST_DELETED)
                    || (cmd.res_status == skt_pkg::ST_FOUND);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_status_reg <= cmd.res_status;
            out_hit_reg    <= found_reg;
            out_pos_reg    <= pos_valid ? skt_pkg::POS_W'(lo_reg) : '0;
            out_stamp_reg  <= (cmd.res_status == skt_pkg::ST_FOUND) ? stamp_reg : '0;
            out_cnt_reg    <= skt_pkg::ECNT_W'(count_reg);
        end
    end

    assign sts.mode        = mode_reg;
    assign sts.search_more = lo_reg < hi_reg;
    assign sts.found       = found_reg;
    assign sts.full        = count_reg == skt_pkg::CNT_W'(skt_pkg::TABLE_DEPTH);
    assign sts.shd_more    = ptr_inc < count_reg;
    assign sts.shu_more    = ptr_reg > lo_reg;
    assign sts.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = skt_pkg::OUT_DATA_W'({out_cnt_reg, out_stamp_reg, out_pos_reg,
                                            out_hit_reg});

endmodule

/* rtl/skt_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted key table controller
// Sequences the binary search, the match check, the shift loops and the
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  skt_pkg::sts_t sts,
    output skt_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_SRCH_CMP,
        S_CHK_CMP,
        S_DECIDE,
        S_SHD_RD,
        S_SHD_WR,
        S_SHU_RD,
        S_SHU_WR,
        S_DONE
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    skt_pkg::status_t status_reg;
    skt_pkg::status_t status_next;

    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        cmd            = '0;
        cmd.res_status = status_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            // The entry at the middle of the window is being read here; once
            // the window is empty that read lands on the final slot.
            S_LOOKUP: begin
                if (sts.mode == skt_pkg::MODE_PURGE) begin
                    cmd.purge   = 1'b1;
                    status_next = skt_pkg::ST_PURGED;
                    state_next  = S_DONE;
                end else if (sts.search_more) begin
                    state_next = S_SRCH_CMP;
                end else begin
                    state_next = S_CHK_CMP;
                end
            end
            S_SRCH_CMP: begin
                cmd.srch_cmp = 1'b1;
                state_next   = S_LOOKUP;
            end
            S_CHK_CMP: begin
                cmd.chk_cmp = 1'b1;
                state_next  = S_DECIDE;
            end
            S_DECIDE: begin
                state_next = S_DONE;
                case (sts.mode)
                    skt_pkg::MODE_CHECK: begin
                        status_next = sts.found ? skt_pkg::ST_FOUND
                                                : skt_pkg::ST_NOT_FOUND;
                    end
                    skt_pkg::MODE_ADD: begin
                        if (sts.found) begin
                            cmd.refresh = 1'b1;
                            status_next = skt_pkg::ST_REFRESHED;
                        end else if (sts.full) begin
                            status_next = skt_pkg::ST_FULL;
                        end else begin
                            cmd.shu_init = 1'b1;
                            status_next  = skt_pkg::ST_ADDED;
                            state_next   = S_SHU_RD;
                        end
                    end
                    skt_pkg::MODE_DELETE: begin
                        if (sts.found) begin
                            cmd.shd_init = 1'b1;
                            status_next  = skt_pkg::ST_DELETED;
                            state_next   = S_SHD_RD;
                        end else begin
                            status_next = skt_pkg::ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        status_next = skt_pkg::ST_PURGED;
                    end
                endcase
            end
            S_SHD_RD: begin
                if (sts.shd_more) begin
                    cmd.shd_rd = 1'b1;
                    state_next = S_SHD_WR;
                end else begin
                    cmd.dec    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SHD_WR: begin
                cmd.shd_wr = 1'b1;
                state_next = S_SHD_RD;
            end
            S_SHU_RD: begin
                if (sts.shu_more) begin
                    cmd.shu_rd = 1'b1;
                    state_next = S_SHU_WR;
                end else begin
                    cmd.put    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SHU_WR: begin
                cmd.shu_wr = 1'b1;
                state_next = S_SHU_RD;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= skt_pkg::ST_NOT_FOUND;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

/* sim/tb_sorted_key_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table core testbench
// Drives check, add, delete and purge requests through the stream ports and
// compares every result against an in-bench model of the sorted table,
// field by field, in order. Both sides idle in random bursts.
// ----------------------------------------------------------------------------

import skt_pkg::*;

// One expected or observed result, unpacked into its fields.
typedef struct {
    status_t            status;
    logic               hit;
    logic [POS_W-1:0]   position;
    logic [STAMP_W-1:0] last_used;
    logic [ECNT_W-1:0]  entry_count;
} table_result_t;

// Holds a copy of the sorted table and the results still owed by the block.
class key_table_scoreboard;
    logic [KEY_WIDTH-1:0] keys   [TABLE_DEPTH];
    logic [STAMP_W-1:0]   stamps [TABLE_DEPTH];
    int unsigned          count;
    table_result_t        owed_q[$];
    int unsigned          errors;

    function new();
        count  = 0;
        errors = 0;
    endfunction

    function int unsigned pending();
        return owed_q.size();
    endfunction

    // Applies one accepted request to the table copy and queues its result.
    function void note_request(mode_t mode, logic [KEY_IN_W-1:0] key_in,
                               logic [STAMP_W-1:0] now);
        table_result_t        r;
        logic [KEY_WIDTH-1:0] key;
        int unsigned          below;
        int unsigned          i;
        bit                   found;
        key = key_in;
        r.status      = ST_NOT_FOUND;
        r.hit         = 1'b0;
        r.position    = '0;
        r.last_used   = '0;
        r.entry_count = '0;
        if (mode == MODE_PURGE) begin
            count    = 0;
            r.status = ST_PURGED;
        end else begin
            // Rank of the key among the valid entries, and whether it is present.
            below = 0;
            found = 1'b0;
            for (i = 0; i < count; i++) begin
                if (keys[i] < key) begin
                    below++;
                end else if (keys[i] == key) begin
                    found = 1'b1;
                end
            end
            if (found) begin
                r.hit      = 1'b1;
                r.position = POS_W'(below);
                case (mode)
                    MODE_CHECK: begin
                        r.status    = ST_FOUND;
                        r.last_used = stamps[below];
                    end
                    MODE_ADD: begin
                        r.status      = ST_REFRESHED;
                        stamps[below] = now;
                    end
                    default: begin
                        for (i = below; i + 1 < count; i++) begin
                            keys[i]   = keys[i + 1];
                            stamps[i] = stamps[i + 1];
                        end
                        count--;
                        r.status = ST_DELETED;
                    end
                endcase
            end else if (mode == MODE_ADD) begin
                if (count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = count; i > below; i--) begin
                        keys[i]   = keys[i - 1];
                        stamps[i] = stamps[i - 1];
                    end
                    keys[below]   = key;
                    stamps[below] = now;
                    count++;
                    r.status   = ST_ADDED;
                    r.position = POS_W'(below);
                end
            end
        end
        r.entry_count = ECNT_W'(count);
        owed_q.push_back(r);
    endfunction

    function void flag(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, want_v, got_v);
        end
    endfunction

    function void check_result(table_result_t got);
        table_result_t want;
        if (owed_q.size() == 0) begin
            errors++;
            $display("%0t: result with no request outstanding, expected none, actual status %0h",
                     $time, got.status);
            return;
        end
        want = owed_q.pop_front();
        flag("status",      want.status,      got.status);
        flag("hit",         want.hit,         got.hit);
        flag("position",    want.position,    got.position);
        flag("last_used",   want.last_used,   got.last_used);
        flag("entry_count", want.entry_count, got.entry_count);
    endfunction
endclass

module tb_sorted_key_table_core;

    localparam int unsigned CYCLE_LIMIT  = 3000000;
    localparam int unsigned RANDOM_ITEMS = 1780;
    localparam int unsigned CALM_ITEMS   = 200;
    localparam int unsigned POOL_SIZE    = 80;
    localparam int unsigned DRAIN_CYCLES = 200;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [MODE_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    key_table_scoreboard   board;
    logic [KEY_IN_W-1:0]   key_pool [POOL_SIZE];
    int unsigned           sent;
    int unsigned           cycles;
    bit                    calm;
    bit                    sender_idles;

    sorted_key_table_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Both channels are sampled at the clock edge, before the edge's updates land.
    always @(posedge aclk) begin
        table_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                board.note_request(mode_t'(s_tuser), s_tdata[0 +: KEY_IN_W],
                                   s_tdata[I_NOW_LSB +: STAMP_W]);
            end
            if (m_tvalid && m_tready) begin
                got.status      = status_t'(m_tuser);
                got.hit         = m_tdata[0];
                got.position    = m_tdata[O_POS_LSB +: POS_W];
                got.last_used   = m_tdata[O_STAMP_LSB +: STAMP_W];
                got.entry_count = m_tdata[O_CNT_LSB +: ECNT_W];
                board.check_result(got);
            end
        end
    end

    // Result side. Mostly ready with random stall bursts; once, early on, a long
    // hold-off so the output register fills and the block stops taking requests.
    initial begin : result_sink
        int unsigned tick;
        int unsigned n;
        int unsigned r;
        bit          held;
        tick = 0;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && tick >= 4000) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (500) @(posedge aclk);
                tick += 500;
            end else if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
                tick++;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    n = $urandom_range(1, 11);
                    m_tready <= 1'b0;
                end else if (r < 18) begin
                    n = $urandom_range(40, 160);
                    m_tready <= 1'b1;
                end else begin
                    n = 1;
                    m_tready <= 1'b1;
                end
                repeat (n) @(posedge aclk);
                tick += n;
            end
        end
    end

    // Offers one request and returns at the edge where it is taken.
    task automatic send_request(mode_t mode, logic [KEY_IN_W-1:0] key,
                                logic [STAMP_W-1:0] now);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= IN_DATA_W'({now, key});
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic sender_gap();
        int unsigned n;
        if (!calm && sender_idles && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Stops offering until every request taken so far has its result back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
    endtask

    function automatic mode_t pick_mode(int unsigned add_w, int unsigned check_w,
                                        int unsigned delete_w);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < add_w) return MODE_ADD;
        if (r < add_w + check_w) return MODE_CHECK;
        if (r < add_w + check_w + delete_w) return MODE_DELETE;
        return MODE_PURGE;
    endfunction

    // Keys mostly come from a small pool so that hits, refreshes and a full
    // table are common; the rest are fresh random keys.
    function automatic logic [KEY_IN_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    function automatic logic [STAMP_W-1:0] pick_stamp();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom();
    endfunction

    task automatic run_phase(int unsigned items, int unsigned add_w,
                             int unsigned check_w, int unsigned delete_w);
        int unsigned k;
        for (k = 0; k < items; k++) begin
            sender_gap();
            send_request(pick_mode(add_w, check_w, delete_w), pick_key(), pick_stamp());
        end
    endtask

    initial begin : stimulus
        int unsigned i;
        int unsigned kind;
        int unsigned len;
        board        = new();
        sent         = 0;
        calm         = 1'b0;
        sender_idles = 1'b1;
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 32'h0000_0001;
        key_pool[3] = 32'hFFFF_FFFE;
        key_pool[4] = 32'h8000_0000;
        for (i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom();

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_CHECK;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests: misses on an empty table, extreme keys and stamps,
        // refresh, hits at both ends and in the middle, deletes, purges.
        send_request(MODE_CHECK,  32'h0000_0000, 32'h0000_0000);
        send_request(MODE_DELETE, 32'h0000_0005, 32'hFFFF_FFFF);
        send_request(MODE_ADD,    32'h8000_0000, 32'hFFFF_FFFF);
        send_request(MODE_ADD,    32'h0000_0000, 32'h0000_0000);
        send_request(MODE_ADD,    32'hFFFF_FFFF, 32'h1234_5678);
        send_request(MODE_ADD,    32'h0000_0001, 32'h0000_0001);
        send_request(MODE_ADD,    32'h8000_0000, 32'hA5A5_A5A5);
        send_request(MODE_CHECK,  32'h0000_0000, 32'hFFFF_FFFF);
        send_request(MODE_CHECK,  32'hFFFF_FFFF, 32'h0000_0000);
        send_request(MODE_CHECK,  32'h8000_0000, 32'h5A5A_5A5A);
        send_request(MODE_CHECK,  32'h0000_0007, 32'h0000_0000);
        send_request(MODE_DELETE, 32'h0000_0000, 32'h0000_0000);
        send_request(MODE_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(MODE_DELETE, 32'h8000_0000, 32'h0000_0000);
        send_request(MODE_DELETE, 32'h8000_0000, 32'h0000_0000);
        send_request(MODE_PURGE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_CHECK,  32'h0000_0001, 32'h0000_0000);
        send_request(MODE_PURGE,  32'h0000_0000, 32'h0000_0000);
        send_request(MODE_ADD,    32'h5555_AAAA, 32'h0F0F_0F0F);
        send_request(MODE_CHECK,  32'h5555_AAAA, 32'h0000_0000);
        wait_for_results();

        // Grow phase long enough to fill the table and then hit it while full.
        run_phase(300, 80, 10, 10);
        wait_for_results();

        // Random mix of growing, mixed and shrinking phases.
        while (sent < RANDOM_ITEMS - CALM_ITEMS) begin
            kind         = $urandom_range(0, 2);
            len          = $urandom_range(40, 180);
            sender_idles = ($urandom_range(0, 3) != 0);
            if (sent + len > RANDOM_ITEMS - CALM_ITEMS) len = RANDOM_ITEMS - CALM_ITEMS - sent;
            case (kind)
                0:       run_phase(len, 70, 15, 14);
                1:       run_phase(len, 35, 34, 29);
                default: run_phase(len, 20, 25, 54);
            endcase
            if ($urandom_range(0, 1) == 0) wait_for_results();
        end

        // Closing stretch with no idling on either side.
        calm = 1'b1;
        run_phase(CALM_ITEMS, 35, 34, 29);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/skt_pkg.sv
rtl/skt_dpath.sv
rtl/skt_ctrl.sv
rtl/sorted_key_table_core.sv
sim/tb_sorted_key_table_core.sv
